// File: hdl/mpr_pkg.sv
package mpr_pkg;

   localparam int N_VALUE_WIDTH  = 31;
   localparam int WORD_WIDTH     = 14;
   localparam int ADDR_WIDTH     = 6;
   localparam int RAM_DEPTH      = 1 << ADDR_WIDTH;
   localparam int PROD_WIDTH     = 2 * WORD_WIDTH;
   localparam int SUM_WIDTH      = PROD_WIDTH + 1;
   localparam int QUOT_WIDTH     = 16;
   localparam int BARRETT_SHIFT  = 43;
   localparam int FACTOR_WIDTH   = 30;
   localparam int BPROD_WIDTH    = SUM_WIDTH + FACTOR_WIDTH;
   localparam int QM_WIDTH       = QUOT_WIDTH + WORD_WIDTH;

   localparam logic [WORD_WIDTH-1:0] MOD_WORD = 14'd10007;
   localparam logic [SUM_WIDTH-1:0]  MOD_SUM  = 29'd10007;
   localparam logic [FACTOR_WIDTH-1:0] BARRETT_FACTOR =
      FACTOR_WIDTH'((64'd1 << BARRETT_SHIFT) / 64'd10007);

   // rows of the fixed matrix, bit c set where column c holds a one
   localparam logic [3:0] BASE_ROWS [4] = '{4'b1111, 4'b0001, 4'b1010, 4'b0110};
   localparam logic [1:0] SEED_WORDS [4] = '{2'd2, 2'd1, 2'd1, 2'd1};

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [ADDR_WIDTH-1:0] addr_type;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_SQR = 2'd1,
      OP_DOT = 2'd2
   } op_type;

   typedef struct packed {
      logic       valid;
      logic       is_first;
      logic       is_last;
      logic       dot;
      logic [1:0] k;
      addr_type   waddr;
   } tag_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } wr_type;

   function automatic word_type init_word(input logic is_sq, input logic [1:0] row,
                                          input logic [1:0] col);
      logic [3:0] bits;
      bits = BASE_ROWS[row];
      if (is_sq) begin
         init_word = WORD_WIDTH'(bits[col]);
      end else begin
         init_word = WORD_WIDTH'(row == col);
      end
   endfunction

   function automatic word_type seed_word(input logic [1:0] k);
      seed_word = WORD_WIDTH'(SEED_WORDS[k]);
   endfunction

endpackage

// File: hdl/mpr_ifaces.sv
interface mpr_req_if;
   import mpr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [N_VALUE_WIDTH-1:0] n_value;
   modport source (output valid, output n_value, input ready);
   modport sink (input valid, input n_value, output ready);
endinterface

interface mpr_rsp_if;
   import mpr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] term_mod;
   modport source (output valid, output term_mod, input ready);
   modport sink (input valid, input term_mod, output ready);
endinterface

// File: hdl/mpr_ram.sv
module mpr_ram (
   input  logic               clock,
   input  mpr_pkg::wr_type    wr,
   input  mpr_pkg::addr_type  raddr_a,
   input  mpr_pkg::addr_type  raddr_b,
   output mpr_pkg::word_type  rd_a,
   output mpr_pkg::word_type  rd_b
);
   import mpr_pkg::*;

   word_type mem [RAM_DEPTH];
   word_type rd_a_ff;
   word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// File: hdl/mpr_mac.sv
module mpr_mac (
   input  logic              clock,
   input  logic              reset,
   input  mpr_pkg::tag_type  issue,
   input  mpr_pkg::word_type rd_a,
   input  mpr_pkg::word_type rd_b,
   output mpr_pkg::wr_type   wr,
   output logic              res_valid,
   output mpr_pkg::word_type res_word,
   output logic              busy
);
   import mpr_pkg::*;

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   tag_type tag3_in;
   logic [PROD_WIDTH-1:0]  prod_ff;
   logic [SUM_WIDTH-1:0]   sum_ff;
   logic [SUM_WIDTH-1:0]   sum4_ff;
   logic [SUM_WIDTH-1:0]   sum5_ff;
   logic [QUOT_WIDTH-1:0]  q_ff;
   logic [SUM_WIDTH-1:0]   qm_ff;
   word_type               b_op;
   logic [BPROD_WIDTH-1:0] bprod;
   logic [QM_WIDTH-1:0]    qm_full;
   logic [SUM_WIDTH-1:0]   diff;
   logic [SUM_WIDTH-1:0]   fixed;

   always_comb begin
      b_op = tag1_ff.dot ? seed_word(tag1_ff.k) : rd_b;
      tag3_in = tag2_ff;
      tag3_in.valid = tag2_ff.valid & tag2_ff.is_last;
      bprod = BPROD_WIDTH'(sum_ff) * BPROD_WIDTH'(BARRETT_FACTOR);
      qm_full = QM_WIDTH'(q_ff) * QM_WIDTH'(MOD_WORD);
      diff = sum5_ff - qm_ff;
      fixed = (diff >= MOD_SUM) ? diff - MOD_SUM : diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
      end else begin
         tag1_ff <= issue;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag3_in;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   // multiply, accumulate four products, then barrett reduction
   always_ff @(posedge clock) begin
      prod_ff <= PROD_WIDTH'(rd_a) * PROD_WIDTH'(b_op);
      if (tag2_ff.valid) begin
         sum_ff <= tag2_ff.is_first ? SUM_WIDTH'(prod_ff) : sum_ff + SUM_WIDTH'(prod_ff);
      end
      q_ff <= bprod[BARRETT_SHIFT +: QUOT_WIDTH];
      sum4_ff <= sum_ff;
      qm_ff <= qm_full[SUM_WIDTH-1:0];
      sum5_ff <= sum4_ff;
   end

   always_comb begin
      wr.en = tag5_ff.valid & ~tag5_ff.dot;
      wr.addr = tag5_ff.waddr;
      wr.data = fixed[WORD_WIDTH-1:0];
   end

   assign res_valid = tag5_ff.valid & tag5_ff.dot;
   assign res_word = fixed[WORD_WIDTH-1:0];
   assign busy = tag1_ff.valid | tag2_ff.valid | tag3_ff.valid | tag4_ff.valid
                 | tag5_ff.valid;

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      tag5_ff.valid |-> fixed < MOD_SUM)
      else $error("reduced word out of range");

   a_sum_only_on_last: assert property (@(posedge clock) disable iff (reset)
      tag3_ff.valid |-> $past(tag2_ff.valid) && $past(tag2_ff.is_last))
      else $error("sum released before the last product");

   a_dot_not_written: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !wr.en)
      else $error("dot result also written to memory");

endmodule

// File: hdl/matrix_power_recurrence_mod_core.sv
// term n of a fixed four-state linear recurrence, modulo 10007
//
// req_chan carries one word, n_value; rsp_chan returns one word, term_mod, per
// request. both use valid/ready, a word moves when both are high.
// for n of 2 or less the answer is n. otherwise a pass loads the identity
// and the base matrix into a 64-word memory, then square-and-multiply runs
// over the bits of n-2. every matrix product is 64 multiply-accumulate steps
// on one shared unit, one per cycle, limited by the single pair of memory
// read ports, and the reduction pipeline drains before the next product may
// read it. n-2 with b bits and c ones needs (b-1) squarings and c multiplies.
// one request is processed at a time; req_chan.ready is high while idle.
// the result sits in an output register, so a new request is taken while the
// previous result waits; a stalled receiver only holds the block once a
// second result is ready.
// reset clears the control state; the memory needs no clearing pass.
module matrix_power_recurrence_mod_core #(
   parameter int INDEX_WIDTH = 31
) (
   input  logic     clock,
   input  logic     reset,
   mpr_req_if.sink  req_chan,
   mpr_rsp_if.source rsp_chan
);
   import mpr_pkg::*;

   localparam int USED_WIDTH = (INDEX_WIDTH < N_VALUE_WIDTH) ? INDEX_WIDTH : N_VALUE_WIDTH;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INIT   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_ISSUE  = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [USED_WIDTH-1:0] p_ff, p_in;
   logic [USED_WIDTH-1:0] n_used;
   logic [5:0]            step_ff, step_in;
   op_type                op_ff, op_in;
   logic                  acc_sel_ff, acc_sel_in;
   logic                  sq_sel_ff, sq_sel_in;
   logic                  mul_done_ff, mul_done_in;
   word_type              res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              term_ff;
   logic                  rsp_load;
   logic                  req_take;

   logic [1:0] a_region, b_region, dst_region;
   addr_type   raddr_a, raddr_b;
   tag_type    issue;
   wr_type     ram_wr, mac_wr;
   word_type   rd_a, rd_b;
   logic       mac_res_valid;
   word_type   mac_res_word;
   logic       mac_busy;

   assign n_used = req_chan.n_value[USED_WIDTH-1:0];
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid & req_chan.ready;
   assign rsp_load = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_chan.ready);

   always_comb begin
      a_region = (op_ff == OP_SQR) ? {1'b1, sq_sel_ff} : {1'b0, acc_sel_ff};
      b_region = {1'b1, sq_sel_ff};
      dst_region = (op_ff == OP_SQR) ? {1'b1, ~sq_sel_ff} : {1'b0, ~acc_sel_ff};
      raddr_a = {a_region, step_ff[5:4], step_ff[1:0]};
      raddr_b = {b_region, step_ff[1:0], step_ff[3:2]};

      issue.valid = (state_ff == ST_ISSUE);
      issue.is_first = (step_ff[1:0] == 2'd0);
      issue.is_last = &step_ff[1:0];
      issue.dot = (op_ff == OP_DOT);
      issue.k = step_ff[1:0];
      issue.waddr = {dst_region, step_ff[5:4], step_ff[3:2]};

      if (state_ff == ST_INIT) begin
         ram_wr.en = 1'b1;
         ram_wr.addr = {step_ff[4], 1'b0, step_ff[3:0]};
         ram_wr.data = init_word(step_ff[4], step_ff[3:2], step_ff[1:0]);
      end else begin
         ram_wr = mac_wr;
      end
   end

   always_comb begin
      state_in = state_ff;
      p_in = p_ff;
      step_in = step_ff;
      op_in = op_ff;
      acc_sel_in = acc_sel_ff;
      sq_sel_in = sq_sel_ff;
      mul_done_in = mul_done_ff;
      res_in = mac_res_valid ? mac_res_word : res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (n_used <= USED_WIDTH'(2)) begin
                  res_in = WORD_WIDTH'(n_used);
                  state_in = ST_DONE;
               end else begin
                  p_in = n_used - USED_WIDTH'(2);
                  step_in = '0;
                  acc_sel_in = 1'b0;
                  sq_sel_in = 1'b0;
                  mul_done_in = 1'b0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            step_in = step_ff + 6'd1;
            if (&step_ff[4:0]) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            step_in = '0;
            if (p_ff == '0) begin
               op_in = OP_DOT;
               state_in = ST_ISSUE;
            end else if (p_ff[0] && !mul_done_ff) begin
               op_in = OP_MUL;
               state_in = ST_ISSUE;
            end else begin
               p_in = p_ff >> 1;
               mul_done_in = 1'b0;
               if ((p_ff >> 1) != '0) begin
                  op_in = OP_SQR;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            step_in = step_ff + 6'd1;
            if ((op_ff == OP_DOT) ? &step_ff[1:0] : &step_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               case (op_ff)
                  OP_MUL: begin
                     acc_sel_in = ~acc_sel_ff;
                     mul_done_in = 1'b1;
                     state_in = ST_DECIDE;
                  end
                  OP_SQR: begin
                     sq_sel_in = ~sq_sel_ff;
                     state_in = ST_DECIDE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff <= p_in;
      step_ff <= step_in;
      op_ff <= op_in;
      acc_sel_ff <= acc_sel_in;
      sq_sel_ff <= sq_sel_in;
      mul_done_ff <= mul_done_in;
      res_ff <= res_in;
      if (rsp_load) begin
         term_ff <= res_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.term_mod = term_ff;

   mpr_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   mpr_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .wr        (mac_wr),
      .res_valid (mac_res_valid),
      .res_word  (mac_res_word),
      .busy      (mac_busy)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      mac_wr.en |-> mac_wr.addr[5:4] != raddr_a[5:4] && mac_wr.addr[5:4] != raddr_b[5:4])
      else $error("writeback hits a region being read");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> !mac_busy && !mac_wr.en)
      else $error("mac active during init");

   a_drain_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && mac_busy |=> state_ff == ST_DRAIN)
      else $error("left drain with pipeline busy");

   a_result_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_res_valid |-> state_ff == ST_DRAIN && op_ff == OP_DOT)
      else $error("dot result outside drain");

endmodule
